[design/pfe_pkg.sv]
// Shared types, codes and helpers for the Playfair digraph encryptor.
// No dependencies; imported by every module of the block but pfe_ram.
package pfe_pkg;

    localparam int unsigned CODE_W  = 5;
    localparam int unsigned SQ_SIDE = 5;
    localparam int unsigned SQ_CELLS = 25;
    localparam int unsigned LETTERS = 26;

    localparam logic [CODE_W-1:0] CODE_X    = 5'd23;
    localparam logic [CODE_W-1:0] CODE_Y    = 5'd24;
    localparam logic [CODE_W-1:0] CODE_Z    = 5'd25;
    localparam logic [CODE_W-1:0] CELLS_C   = 5'd25;
    localparam logic [CODE_W-1:0] LAST_CELL = 5'd24;

    typedef enum logic [1:0] {
        OP_KEY      = 2'd0,
        OP_KEY_END  = 2'd1,
        OP_TEXT     = 2'd2,
        OP_TEXT_END = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD_A,
        ST_RD_B,
        ST_CALC,
        ST_RD_KA,
        ST_RD_KB,
        ST_LOAD,
        ST_EMIT_Z
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic place_key;
        logic fill_start;
        logic fill_step;
        logic set_done;
        logic pend_store;
        logic pair_text;
        logic pair_end;
        logic rd_pa;
        logic rd_pb;
        logic calc;
        logic rd_ka;
        logic rd_kb;
        logic load_pair;
        logic load_z;
    } pfe_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic key_done;
        logic pend_valid;
        logic key_ok;
        logic text_ok;
        logic is_z;
        logic fill_last;
        logic buf_empty;
    } pfe_stat_t;

    function automatic logic [2:0] row_of(input logic [CODE_W-1:0] p);
        logic [2:0] r;
        if (p >= 5'd20)
            r = 3'd4;
        else if (p >= 5'd15)
            r = 3'd3;
        else if (p >= 5'd10)
            r = 3'd2;
        else if (p >= 5'd5)
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    // cell index = row * 5 + col
    function automatic logic [CODE_W-1:0] cell_at(input logic [2:0] r, input logic [2:0] c);
        return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic logic [2:0] col_of(input logic [CODE_W-1:0] p);
        logic [CODE_W-1:0] base;
        base = cell_at(row_of(p), 3'd0);
        return 3'(p - base);
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [CODE_W-1:0] filler_for(input logic [CODE_W-1:0] code);
        return (code == CODE_X) ? CODE_Y : CODE_X;
    endfunction

endpackage

[design/pfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/pfe_ctrl.sv]
// Sequencing state machine for the Playfair encryptor.
// Depends on pfe_pkg; drives the datapath by pfe_cmd_t, reads pfe_stat_t.
module pfe_ctrl
    import pfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  op_t       operation,
    input  pfe_stat_t stat,
    output pfe_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;
    logic       take;

    assign item_stall = (state_reg != ST_IDLE);
    assign take       = item_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (operation)
                        OP_KEY_END:
                        begin
                            if (!stat.key_done)
                                state_next = ST_FILL;
                        end
                        OP_TEXT:
                        begin
                            if (stat.key_done && stat.text_ok)
                            begin
                                if (stat.is_z)
                                    state_next = ST_EMIT_Z;
                                else if (stat.pend_valid)
                                    state_next = ST_RD_A;
                            end
                        end
                        OP_TEXT_END:
                        begin
                            if (stat.key_done && stat.pend_valid)
                                state_next = ST_RD_A;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (stat.fill_last)
                    state_next = ST_IDLE;
            end
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_CALC;
            ST_CALC:   state_next = ST_RD_KA;
            ST_RD_KA:  state_next = ST_RD_KB;
            ST_RD_KB:  state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (stat.buf_empty)
                    state_next = ST_IDLE;
            end
            ST_EMIT_Z:
            begin
                if (stat.buf_empty)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (operation)
                        OP_KEY:
                        begin
                            cmd.place_key = !stat.key_done && stat.key_ok;
                        end
                        OP_KEY_END:
                        begin
                            cmd.fill_start = !stat.key_done;
                        end
                        OP_TEXT:
                        begin
                            if (stat.key_done && stat.text_ok && !stat.is_z)
                            begin
                                cmd.pend_store = !stat.pend_valid;
                                cmd.pair_text  = stat.pend_valid;
                            end
                        end
                        OP_TEXT_END:
                        begin
                            cmd.pair_end = stat.key_done && stat.pend_valid;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.set_done  = stat.fill_last;
            end
            ST_RD_A:   cmd.rd_pa = 1'b1;
            ST_RD_B:   cmd.rd_pb = 1'b1;
            ST_CALC:   cmd.calc  = 1'b1;
            ST_RD_KA:  cmd.rd_ka = 1'b1;
            ST_RD_KB:  cmd.rd_kb = 1'b1;
            ST_LOAD:   cmd.load_pair = stat.buf_empty;
            ST_EMIT_Z: cmd.load_z    = stat.buf_empty;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[design/pfe_datapath.sv]
// Datapath: key square and letter position RAMs, pair logic, result buffer.
// Depends on pfe_pkg and pfe_ram; commanded by pfe_ctrl.
module pfe_datapath
    import pfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CODE_W-1:0] letter,
    input  pfe_cmd_t          cmd,
    output pfe_stat_t         stat,
    input  logic              result_stall,
    output logic              result_valid,
    output logic [CODE_W-1:0] cipher_letter,
    output logic              last
);

    logic [LETTERS-1:0] used_reg, used_next;
    logic [CODE_W-1:0]  fill_reg, fill_next;
    logic [CODE_W-1:0]  scan_reg, scan_next;
    logic               key_done_reg, key_done_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0]  pend_reg, pend_next;
    logic [CODE_W-1:0]  a_reg, a_next;
    logic [CODE_W-1:0]  b_reg, b_next;
    logic [CODE_W-1:0]  pa_reg;
    logic [CODE_W-1:0]  na_reg, nb_reg;
    logic [CODE_W-1:0]  c0_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic [CODE_W-1:0]  slot0_reg, slot0_next;
    logic               slot0_last_reg, slot0_last_next;
    logic [CODE_W-1:0]  slot1_reg, slot1_next;

    logic               full;
    logic               scan_free;
    logic               place;
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  pos_rdata, key_rdata;
    logic [CODE_W-1:0]  pos_raddr, key_raddr;
    logic [2:0]         ra, rb, ca, cb;
    logic [CODE_W-1:0]  na, nb;
    logic               word_out;

    assign full      = (fill_reg >= CELLS_C);
    assign scan_free = !used_reg[scan_reg];
    assign place     = cmd.place_key || (cmd.fill_step && !full && scan_free);
    assign code      = cmd.fill_step ? scan_reg : letter;

    assign stat.key_done   = key_done_reg;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.key_ok     = (letter < CELLS_C) && !used_reg[letter] && !full;
    assign stat.text_ok    = (letter <= CODE_Z);
    assign stat.is_z       = (letter == CODE_Z);
    assign stat.fill_last  = (scan_reg == LAST_CELL) || full;
    assign stat.buf_empty  = (cnt_reg == 2'd0);

    assign pos_raddr = cmd.rd_pa ? a_reg : b_reg;
    assign key_raddr = cmd.rd_ka ? na_reg : nb_reg;

    pfe_ram #(.WIDTH(CODE_W), .DEPTH(SQ_CELLS)) u_square (
        .clk   (clk),
        .we    (place),
        .waddr (fill_reg),
        .wdata (code),
        .re    (cmd.rd_ka || cmd.rd_kb),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    pfe_ram #(.WIDTH(CODE_W), .DEPTH(LETTERS)) u_position (
        .clk   (clk),
        .we    (place),
        .waddr (code),
        .wdata (fill_reg),
        .re    (cmd.rd_pa || cmd.rd_pb),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // pa from the holding register, pb straight off the RAM
    always_comb
    begin
        ra = row_of(pa_reg);
        ca = col_of(pa_reg);
        rb = row_of(pos_rdata);
        cb = col_of(pos_rdata);
        if (ra == rb)
        begin
            na = cell_at(ra, wrap_inc(ca));
            nb = cell_at(rb, wrap_inc(cb));
        end
        else if (ca == cb)
        begin
            na = cell_at(wrap_inc(ra), ca);
            nb = cell_at(wrap_inc(rb), cb);
        end
        else
        begin
            na = cell_at(ra, cb);
            nb = cell_at(rb, ca);
        end
    end

    always_comb
    begin
        used_next       = used_reg;
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        key_done_next   = key_done_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        a_next          = a_reg;
        b_next          = b_reg;

        if (place)
        begin
            used_next[code] = 1'b1;
            fill_next       = fill_reg + 5'd1;
        end
        if (cmd.fill_start)
            scan_next = '0;
        else if (cmd.fill_step)
            scan_next = scan_reg + 5'd1;
        if (cmd.set_done)
            key_done_next = 1'b1;

        if (cmd.pend_store)
        begin
            pend_valid_next = 1'b1;
            pend_next       = letter;
        end
        if (cmd.pair_text)
        begin
            a_next = pend_reg;
            // doubled pair: pad the first, the second keeps waiting
            if (letter == pend_reg)
            begin
                b_next = filler_for(letter);
            end
            else
            begin
                b_next          = letter;
                pend_valid_next = 1'b0;
            end
        end
        if (cmd.pair_end)
        begin
            a_next          = pend_reg;
            b_next          = filler_for(pend_reg);
            pend_valid_next = 1'b0;
        end
    end

    assign word_out = result_valid && !result_stall;

    always_comb
    begin
        cnt_next        = cnt_reg;
        slot0_next      = slot0_reg;
        slot0_last_next = slot0_last_reg;
        slot1_next      = slot1_reg;
        if (cmd.load_pair)
        begin
            cnt_next        = 2'd2;
            slot0_next      = c0_reg;
            slot0_last_next = 1'b0;
            slot1_next      = key_rdata;
        end
        else if (cmd.load_z)
        begin
            cnt_next        = 2'd1;
            slot0_next      = CODE_Z;
            slot0_last_next = 1'b1;
        end
        else if (word_out)
        begin
            cnt_next        = cnt_reg - 2'd1;
            slot0_next      = slot1_reg;
            slot0_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            fill_reg       <= '0;
            scan_reg       <= '0;
            key_done_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            scan_reg       <= scan_next;
            key_done_reg   <= key_done_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        slot0_reg      <= slot0_next;
        slot0_last_reg <= slot0_last_next;
        slot1_reg      <= slot1_next;
        if (cmd.rd_pb)
            pa_reg <= pos_rdata;
        if (cmd.calc)
        begin
            na_reg <= na;
            nb_reg <= nb;
        end
        if (cmd.rd_kb)
            c0_reg <= key_rdata;
    end

    assign result_valid  = (cnt_reg != 2'd0);
    assign cipher_letter = slot0_reg;
    assign last          = slot0_last_reg;

endmodule

[design/playfair_digraph_encryptor_top.sv]
// Top level of the Playfair digraph encryptor: controller plus datapath.
// Depends on pfe_pkg, pfe_ctrl, pfe_datapath (and pfe_ram below it).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------
//  item     | item_valid / item_stall    | operation[1:0], letter[4:0]
//  result   | result_valid / result_stall| cipher_letter[4:0], last
//
// Key letters, lone text letters and ignored words are handled in the idle state.
// Key end walks the alphabet one letter a cycle until the square is full.
// A text pair runs through two position RAM reads, the cell calc, two square
// RAM reads and the load into the two-word result buffer; Z goes straight to its load.
// Reset is async active low and needs no clearing pass. A full result
// buffer holds a new pair at its load step until the last word has gone.
module playfair_digraph_encryptor_top
    import pfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        operation,
    input  logic [CODE_W-1:0] letter,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [CODE_W-1:0] cipher_letter,
    output logic              last
);

    pfe_cmd_t  cmd;
    pfe_stat_t stat;

    pfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (op_t'(operation)),
        .stat       (stat),
        .cmd        (cmd)
    );

    pfe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .letter        (letter),
        .cmd           (cmd),
        .stat          (stat),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .cipher_letter (cipher_letter),
        .last          (last)
    );

endmodule

[verif/tb_playfair_digraph_encryptor_top.sv]
// Self-checking testbench for playfair_digraph_encryptor_top: builds one key
// square, then streams text and checks every cipher word against a predictor.
// Depends on pfe_pkg and the design files only.
`timescale 1ns / 100ps

module tb_playfair_digraph_encryptor_top;
    import pfe_pkg::*;

    localparam int RANDOM_WORDS = 1600;
    localparam int CALM_WORDS   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              tail;
    } cipher_word_t;

    // Tracks the square and the waiting letter, and queues the cipher words due.
    class cipher_scoreboard;
        logic [CODE_W-1:0] square[SQ_CELLS];
        int                where_is[LETTERS];
        logic [LETTERS-1:0] used;
        int                filled;
        bit                square_ready;
        bit                have_pending;
        logic [CODE_W-1:0] held;
        cipher_word_t      cipher_q[$];
        int                failures;
        int                checked;
        int                pairs;
        int                z_passes;

        function new();
            used = '0;
            filled = 0;
            square_ready = 1'b0;
            have_pending = 1'b0;
            held = '0;
            failures = 0;
            checked = 0;
            pairs = 0;
            z_passes = 0;
        endfunction

        function void place(logic [CODE_W-1:0] code);
            if (filled < SQ_CELLS && code < CELLS_C)
            begin
                square[filled] = code;
                where_is[code] = filled;
                used[code] = 1'b1;
                filled++;
            end
        endfunction

        function logic [CODE_W-1:0] pad_for(logic [CODE_W-1:0] code);
            return (code == CODE_X) ? CODE_Y : CODE_X;
        endfunction

        function void encipher(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
            int ra, ca, rb, cb, na, nb;
            ra = where_is[a] / SQ_SIDE;
            ca = where_is[a] % SQ_SIDE;
            rb = where_is[b] / SQ_SIDE;
            cb = where_is[b] % SQ_SIDE;
            if (ra == rb)
            begin
                na = ra * SQ_SIDE + (ca + 1) % SQ_SIDE;
                nb = rb * SQ_SIDE + (cb + 1) % SQ_SIDE;
            end
            else if (ca == cb)
            begin
                na = ((ra + 1) % SQ_SIDE) * SQ_SIDE + ca;
                nb = ((rb + 1) % SQ_SIDE) * SQ_SIDE + cb;
            end
            else
            begin
                na = ra * SQ_SIDE + cb;
                nb = rb * SQ_SIDE + ca;
            end
            cipher_q.push_back('{code: square[na], tail: 1'b0});
            cipher_q.push_back('{code: square[nb], tail: 1'b1});
            pairs++;
        endfunction

        function void note_word(op_t op, logic [CODE_W-1:0] code);
            case (op)
                OP_KEY:
                    if (!square_ready && code < CELLS_C && !used[code])
                        place(code);
                OP_KEY_END:
                    if (!square_ready)
                    begin
                        for (int j = 0; j < SQ_CELLS; j++)
                            if (!used[j])
                                place(CODE_W'(j));
                        square_ready = 1'b1;
                    end
                OP_TEXT:
                    if (square_ready && code <= CODE_Z)
                    begin
                        if (code == CODE_Z)
                        begin
                            // Z passes straight through, waiting letter untouched
                            cipher_q.push_back('{code: CODE_Z, tail: 1'b1});
                            z_passes++;
                        end
                        else if (!have_pending)
                        begin
                            have_pending = 1'b1;
                            held = code;
                        end
                        else if (code == held)
                            encipher(held, pad_for(code));
                        else
                        begin
                            have_pending = 1'b0;
                            encipher(held, code);
                        end
                    end
                default:
                    if (square_ready && have_pending)
                    begin
                        have_pending = 1'b0;
                        encipher(held, pad_for(held));
                    end
            endcase
        endfunction

        function void check_word(logic [CODE_W-1:0] code, logic tail);
            cipher_word_t due;
            if (cipher_q.size() == 0)
            begin
                $error("unexpected word: cipher_letter %0d last %0b", code, tail);
                failures++;
            end
            else
            begin
                due = cipher_q.pop_front();
                checked++;
                if (code !== due.code)
                begin
                    $error("cipher_letter: expected %0d, got %0d", due.code, code);
                    failures++;
                end
                if (tail !== due.tail)
                begin
                    $error("last: expected %0b, got %0b", due.tail, tail);
                    failures++;
                end
            end
        endfunction

        function int outstanding();
            return cipher_q.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    logic [1:0]        operation;
    logic [CODE_W-1:0] letter;
    logic              result_valid;
    logic              result_stall;
    logic [CODE_W-1:0] cipher_letter;
    logic              last;

    cipher_scoreboard sb;
    bit idle_on;
    bit hold_req;
    int words_sent;

    playfair_digraph_encryptor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .letter        (letter),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .cipher_letter (cipher_letter),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_word(input op_t op, input logic [CODE_W-1:0] code);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation <= op;
        letter <= code;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_word(op, code);
        words_sent++;
    endtask

    // Result side: check accepted words, then pick the next stall value.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        result_stall = 1'b0;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_word(cipher_letter, last);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        logic [CODE_W-1:0] k0;
        logic [CODE_W-1:0] prev;
        logic [CODE_W-1:0] perm[SQ_CELLS];
        logic [CODE_W-1:0] tmp;
        int n_key;
        int counted;
        int next_mark;
        int pick;
        int r;
        int c;
        int s;
        bit held_off;
        bit paused;

        sb = new();
        idle_on = 1'b1;
        hold_req = 1'b0;
        words_sent = 0;
        item_valid = 1'b0;
        operation = OP_KEY;
        letter = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // text before key end is dropped
        send_word(OP_TEXT, CODE_W'($urandom_range(0, 24)));
        send_word(OP_TEXT_END, CODE_W'($urandom_range(0, 31)));

        k0 = CODE_W'($urandom_range(0, 24));
        send_word(OP_KEY, k0);
        send_word(OP_KEY, k0);
        send_word(OP_KEY, CODE_Z);
        send_word(OP_KEY, 5'd31);
        send_word(OP_KEY, 5'd26);
        if ($urandom_range(0, 3) == 0)
        begin
            // whole square from the key, then one word with the square full
            for (int j = 0; j < SQ_CELLS; j++)
                perm[j] = CODE_W'(j);
            for (int j = SQ_CELLS - 1; j > 0; j--)
            begin
                s = $urandom_range(0, j);
                tmp = perm[j];
                perm[j] = perm[s];
                perm[s] = tmp;
            end
            for (int j = 0; j < SQ_CELLS; j++)
                send_word(OP_KEY, perm[j]);
            send_word(OP_KEY, CODE_W'($urandom_range(0, 24)));
        end
        else
        begin
            n_key = $urandom_range(0, 30);
            for (int j = 0; j < n_key; j++)
                send_word(OP_KEY, CODE_W'($urandom_range(0, 31)));
        end
        send_word(OP_KEY_END, CODE_W'($urandom_range(0, 31)));
        send_word(OP_KEY_END, CODE_W'($urandom_range(0, 31)));
        send_word(OP_KEY, CODE_W'($urandom_range(0, 24)));

        r = $urandom_range(0, 4);
        c = $urandom_range(0, 4);
        // same row across the wrap, same column across the wrap, rectangle
        send_word(OP_TEXT, sb.square[r * SQ_SIDE + 4]);
        send_word(OP_TEXT, sb.square[r * SQ_SIDE]);
        send_word(OP_TEXT, sb.square[20 + c]);
        send_word(OP_TEXT, sb.square[c]);
        send_word(OP_TEXT, sb.square[0]);
        send_word(OP_TEXT, sb.square[24]);
        // doubled X takes Y; a waiting X survives Z and bad codes
        send_word(OP_TEXT, CODE_X);
        send_word(OP_TEXT, CODE_X);
        send_word(OP_TEXT, CODE_Z);
        send_word(OP_TEXT, 5'd31);
        send_word(OP_TEXT, CODE_X);
        send_word(OP_TEXT_END, 5'd31);
        send_word(OP_TEXT_END, 5'd0);
        send_word(OP_TEXT, 5'd0);
        send_word(OP_TEXT, 5'd0);
        send_word(OP_TEXT_END, 5'd0);

        counted = 0;
        next_mark = 0;
        held_off = 1'b0;
        paused = 1'b0;
        prev = 5'd0;
        while (counted < RANDOM_WORDS)
        begin
            if (counted >= next_mark)
            begin
                next_mark = counted + 100;
                idle_on = (counted < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
            end
            if (!held_off && counted >= 500)
            begin
                held_off = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && counted >= 1000)
            begin
                paused = 1'b1;
                item_valid <= 1'b0;
                @(posedge clk);
                while (sb.outstanding() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 3) != 0)
                    prev = CODE_W'($urandom_range(0, 24));
                send_word(OP_TEXT, prev);
            end
            else if (pick < 78)
                send_word(OP_TEXT, CODE_Z);
            else if (pick < 87)
                send_word(OP_TEXT_END, CODE_W'($urandom_range(0, 31)));
            else if (pick < 91)
                send_word(OP_TEXT, CODE_W'($urandom_range(26, 31)));
            else if (pick < 96)
                send_word(OP_KEY, CODE_W'($urandom_range(0, 31)));
            else
                send_word(OP_KEY_END, CODE_W'($urandom_range(0, 31)));
            counted++;
        end
        send_word(OP_TEXT_END, 5'd0);
        item_valid <= 1'b0;
        idle_on = 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input words and %0d checked cipher words", words_sent,
                 sb.checked);
        $display("  (%0d pairs enciphered, %0d Z pass-throughs)", sb.pairs, sb.z_passes);
        if (sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
